// File: hdl/vdlv_pkg.sv
package vdlv_pkg;

    // Field widths.
    localparam int COORD_BITS  = 24;
    localparam int COUNT_BITS  = 16;
    localparam int DIR_BITS    = 16;
    localparam int COS_BITS    = 32;
    localparam int MIN_RATIO_BITS = 17;
    localparam int TOTAL_BITS  = 16;
    localparam int STATUS_BITS = 2;

    // Configuration port.
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Shared multiply-accumulate unit. Wide values are split into 32-bit limbs.
    localparam int LIMB       = 32;
    localparam int OPND_BITS  = LIMB + 1;
    localparam int PROD_BITS  = 2 * OPND_BITS;
    localparam int ACC_BITS   = 128;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int DOT_BITS   = DIFF_BITS + DIR_BITS + 2;
    localparam int VN_BITS    = 2 * DIR_BITS;
    localparam int DN_BITS    = 2 * DIFF_BITS;
    localparam int P_BITS     = DN_BITS + VN_BITS;
    localparam int R_BITS     = P_BITS + COS_BITS;
    localparam int RATIO_BITS = COUNT_BITS + MIN_RATIO_BITS;

    localparam int STEP_BITS = 5;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(22);

    typedef enum logic [2:0] {
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_COS_SQ,
        REG_MIN_INLIERS,
        REG_MIN_RATIO
    } t_reg;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_INLIER,
        STAT_OUTLIER,
        STAT_DEGEN
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic signed [DIR_BITS-1:0]  dir_x;
        logic signed [DIR_BITS-1:0]  dir_y;
        logic signed [DIR_BITS-1:0]  dir_z;
        logic [COS_BITS-1:0]         cos_sq;
        logic [COUNT_BITS-1:0]       min_inliers;
        logic [MIN_RATIO_BITS-1:0]   min_ratio;
    } t_cfg;

    // Operand sources of the shared multiplier.
    typedef enum logic [4:0] {
        OP_ZERO,
        OP_DX,
        OP_DY,
        OP_DZ,
        OP_VX,
        OP_VY,
        OP_VZ,
        OP_DN_LO,
        OP_DN_HI,
        OP_VN,
        OP_P_LO,
        OP_P_MID,
        OP_P_HI,
        OP_COS,
        OP_DOT_LO,
        OP_DOT_HI,
        OP_DOT_HI2,
        OP_RATIO,
        OP_LINE
    } t_opnd;

    localparam int NUM_OPND = 19;

    // Where the accumulator is saved once a partial result is complete.
    typedef enum logic [2:0] {
        STORE_NONE,
        STORE_RATIO,
        STORE_VN,
        STORE_DN,
        STORE_P,
        STORE_R,
        STORE_DOT
    } t_store;

    typedef struct packed {
        logic        valid;
        t_opnd       a;
        t_opnd       b;
        logic [1:0]  shift;
        logic        clear;
        t_store      store;
    } t_uop;

    localparam t_uop UOP_NOP = '{
        valid: 1'b0, a: OP_ZERO, b: OP_ZERO, shift: 2'd0, clear: 1'b0, store: STORE_NONE
    };

    function automatic t_uop mk_uop(t_opnd a, t_opnd b, logic [1:0] shift, logic clear,
                                    t_store store);
        t_uop u;
        u.valid = 1'b1;
        u.a     = a;
        u.b     = b;
        u.shift = shift;
        u.clear = clear;
        u.store = store;
        return u;
    endfunction

    // Micro-program. A product is registered before it is added into the accumulator,
    // so an empty step separates a stored result from its first use.
    function automatic t_uop micro_op(logic [STEP_BITS-1:0] step);
        t_uop u;
        u = UOP_NOP;
        case (step)
            5'd0:  u = mk_uop(OP_RATIO,  OP_LINE,    2'd0, 1'b1, STORE_RATIO);
            5'd1:  u = mk_uop(OP_VX,     OP_VX,      2'd0, 1'b1, STORE_NONE);
            5'd2:  u = mk_uop(OP_VY,     OP_VY,      2'd0, 1'b0, STORE_NONE);
            5'd3:  u = mk_uop(OP_VZ,     OP_VZ,      2'd0, 1'b0, STORE_VN);
            5'd4:  u = mk_uop(OP_DX,     OP_DX,      2'd0, 1'b1, STORE_NONE);
            5'd5:  u = mk_uop(OP_DY,     OP_DY,      2'd0, 1'b0, STORE_NONE);
            5'd6:  u = mk_uop(OP_DZ,     OP_DZ,      2'd0, 1'b0, STORE_DN);
            5'd8:  u = mk_uop(OP_DN_LO,  OP_VN,      2'd0, 1'b1, STORE_NONE);
            5'd9:  u = mk_uop(OP_DN_HI,  OP_VN,      2'd1, 1'b0, STORE_P);
            5'd11: u = mk_uop(OP_P_LO,   OP_COS,     2'd0, 1'b1, STORE_NONE);
            5'd12: u = mk_uop(OP_P_MID,  OP_COS,     2'd1, 1'b0, STORE_NONE);
            5'd13: u = mk_uop(OP_P_HI,   OP_COS,     2'd2, 1'b0, STORE_R);
            5'd14: u = mk_uop(OP_DX,     OP_VX,      2'd0, 1'b1, STORE_NONE);
            5'd15: u = mk_uop(OP_DY,     OP_VY,      2'd0, 1'b0, STORE_NONE);
            5'd16: u = mk_uop(OP_DZ,     OP_VZ,      2'd0, 1'b0, STORE_DOT);
            5'd18: u = mk_uop(OP_DOT_LO, OP_DOT_LO,  2'd0, 1'b1, STORE_NONE);
            5'd19: u = mk_uop(OP_DOT_LO, OP_DOT_HI2, 2'd1, 1'b0, STORE_NONE);
            5'd20: u = mk_uop(OP_DOT_HI, OP_DOT_HI,  2'd2, 1'b0, STORE_NONE);
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

// File: hdl/vanishing_direction_line_verifier_top.sv
// Vanishing-direction line verifier. Each input transaction carries one 3D segment
// (start and end point) of a line group; the block forms d = end - start and, for a
// nonzero d, calls the segment an inlier when (d.v)^2 * 2^32 > cos_sq * |d|^2 * |v|^2,
// with v and cos_sq taken from the configuration registers. A zero d is reported as
// degenerate. Every input transaction produces exactly one output transaction with the
// line status and the running, saturating inlier and line counts; the segment flagged
// last_line closes the group, reports whether the minimum count and minimum ratio both
// pass, and clears the counts. All products go through one 33x33 signed multiplier
// followed by a 128-bit accumulator, stepped by a 23-step micro-program: the multiplier
// is the pacing unit, so a segment occupies the block from its acceptance until its
// micro-program ends, longer only while an earlier result still waits at the output.
// The output register lets a new segment enter while the
// previous result is still waiting to be taken. Configuration is written over an
// APB-style port (registers at byte offsets 0x00 to 0x14, always ready) and must only
// be changed while no segment is in flight.
module vanishing_direction_line_verifier_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [vdlv_pkg::COORD_BITS-1:0]  i_start_x,
    input  logic signed [vdlv_pkg::COORD_BITS-1:0]  i_start_y,
    input  logic signed [vdlv_pkg::COORD_BITS-1:0]  i_start_z,
    input  logic signed [vdlv_pkg::COORD_BITS-1:0]  i_end_x,
    input  logic signed [vdlv_pkg::COORD_BITS-1:0]  i_end_y,
    input  logic signed [vdlv_pkg::COORD_BITS-1:0]  i_end_z,
    input  logic                                    i_last_line,

    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [vdlv_pkg::STATUS_BITS-1:0]        o_line_status,
    output logic                                    o_group_done,
    output logic                                    o_group_passed,
    output logic [vdlv_pkg::TOTAL_BITS-1:0]         o_inlier_total,
    output logic [vdlv_pkg::TOTAL_BITS-1:0]         o_line_total,

    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [vdlv_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [vdlv_pkg::DATA_BITS-1:0]          pwdata,
    output logic [vdlv_pkg::DATA_BITS-1:0]          prdata,
    output logic                                    pready
);
    import vdlv_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_cfg                    cfg;
    t_state                  r_state;
    t_state                  n_state;
    logic [STEP_BITS-1:0]    r_step;
    logic [STEP_BITS-1:0]    n_step;
    t_uop                    uop;
    logic                    in_fire;
    logic                    finish;

    // Segment held for the whole computation.
    logic signed [DIFF_BITS-1:0] r_dx;
    logic signed [DIFF_BITS-1:0] r_dy;
    logic signed [DIFF_BITS-1:0] r_dz;
    logic                        r_degen;
    logic                        r_last;

    logic [COUNT_BITS-1:0]   r_inl_cnt;
    logic [COUNT_BITS-1:0]   r_line_cnt;
    logic [COUNT_BITS-1:0]   line_next;
    logic [COUNT_BITS-1:0]   inl_next;
    logic                    gt;
    logic [RATIO_BITS-1:0]   ratio_rhs;
    t_status                 status;
    logic                    passed;

    logic                    r_out_valid;
    t_status                 r_status;
    logic                    r_done;
    logic                    r_passed;
    logic [TOTAL_BITS-1:0]   r_inl_total;
    logic [TOTAL_BITS-1:0]   r_line_total;

    vdlv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vdlv_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (uop),
        .i_cfg       (cfg),
        .i_dx        (r_dx),
        .i_dy        (r_dy),
        .i_dz        (r_dz),
        .i_line_next (line_next),
        .o_gt        (gt),
        .o_ratio     (ratio_rhs)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid & o_in_ready;

    // The line count after this segment does not depend on the test outcome, so the
    // ratio threshold product min_ratio * line_count can be formed in the first step.
    assign line_next = (r_line_cnt == COUNT_MAX) ? r_line_cnt : r_line_cnt + 1'b1;

    always_comb begin
        if (r_degen) begin
            status = STAT_DEGEN;
        end else if (gt) begin
            status = STAT_INLIER;
        end else begin
            status = STAT_OUTLIER;
        end
        if (status == STAT_INLIER && r_inl_cnt != COUNT_MAX) begin
            inl_next = r_inl_cnt + 1'b1;
        end else begin
            inl_next = r_inl_cnt;
        end
        passed = r_last
               && (inl_next >= cfg.min_inliers)
               && (RATIO_BITS'({inl_next, 16'b0}) >= ratio_rhs);
    end

    // Sequencer: steps through the micro-program, then holds on the final step
    // until the output register is free to take the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        uop     = UOP_NOP;
        finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (in_fire) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                uop = micro_op(r_step);
                if (r_step == LAST_STEP) begin
                    if (!r_out_valid || i_out_ready) begin
                        finish  = 1'b1;
                        n_state = ST_IDLE;
                        n_step  = '0;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // Capture the segment as its direction vector.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dx    <= DIFF_BITS'(i_end_x) - DIFF_BITS'(i_start_x);
            r_dy    <= DIFF_BITS'(i_end_y) - DIFF_BITS'(i_start_y);
            r_dz    <= DIFF_BITS'(i_end_z) - DIFF_BITS'(i_start_z);
            r_degen <= (i_end_x == i_start_x) && (i_end_y == i_start_y)
                    && (i_end_z == i_start_z);
            r_last  <= i_last_line;
        end
    end

    // Group counters; a closing segment clears them once its result is issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inl_cnt  <= '0;
            r_line_cnt <= '0;
        end else if (finish) begin
            if (r_last) begin
                r_inl_cnt  <= '0;
                r_line_cnt <= '0;
            end else begin
                r_inl_cnt  <= inl_next;
                r_line_cnt <= line_next;
            end
        end
    end

    // Output register. A result stays until its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status     <= status;
            r_done       <= r_last;
            r_passed     <= passed;
            r_inl_total  <= TOTAL_BITS'(inl_next);
            r_line_total <= TOTAL_BITS'(line_next);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_status  = r_status;
    assign o_group_done   = r_done;
    assign o_group_passed = r_passed;
    assign o_inlier_total = r_inl_total;
    assign o_line_total   = r_line_total;

endmodule

// File: hdl/vdlv_regs.sv
module vdlv_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vdlv_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [vdlv_pkg::DATA_BITS-1:0]  pwdata,
    output logic [vdlv_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready,
    output vdlv_pkg::t_cfg                  o_cfg
);
    import vdlv_pkg::*;

    t_cfg r_cfg;
    t_reg idx;
    logic wr_en;

    assign idx    = t_reg'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_x       <= '0;
            r_cfg.dir_y       <= '0;
            r_cfg.dir_z       <= DIR_BITS'(32767);
            r_cfg.cos_sq      <= COS_BITS'(32'hD000_0000);
            r_cfg.min_inliers <= COUNT_BITS'(2);
            r_cfg.min_ratio   <= MIN_RATIO_BITS'(32768);
        end else if (wr_en) begin
            case (idx)
                REG_DIR_X:       r_cfg.dir_x       <= pwdata[DIR_BITS-1:0];
                REG_DIR_Y:       r_cfg.dir_y       <= pwdata[DIR_BITS-1:0];
                REG_DIR_Z:       r_cfg.dir_z       <= pwdata[DIR_BITS-1:0];
                REG_COS_SQ:      r_cfg.cos_sq      <= pwdata[COS_BITS-1:0];
                REG_MIN_INLIERS: r_cfg.min_inliers <= pwdata[COUNT_BITS-1:0];
                REG_MIN_RATIO:   r_cfg.min_ratio   <= pwdata[MIN_RATIO_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DIR_X:       prdata = DATA_BITS'(r_cfg.dir_x);
            REG_DIR_Y:       prdata = DATA_BITS'(r_cfg.dir_y);
            REG_DIR_Z:       prdata = DATA_BITS'(r_cfg.dir_z);
            REG_COS_SQ:      prdata = DATA_BITS'(r_cfg.cos_sq);
            REG_MIN_INLIERS: prdata = DATA_BITS'(r_cfg.min_inliers);
            REG_MIN_RATIO:   prdata = DATA_BITS'(r_cfg.min_ratio);
            default:         prdata = '0;
        endcase
    end

endmodule

// File: hdl/vdlv_mac.sv
module vdlv_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  vdlv_pkg::t_uop                          i_uop,
    input  vdlv_pkg::t_cfg                          i_cfg,
    input  logic signed [vdlv_pkg::DIFF_BITS-1:0]   i_dx,
    input  logic signed [vdlv_pkg::DIFF_BITS-1:0]   i_dy,
    input  logic signed [vdlv_pkg::DIFF_BITS-1:0]   i_dz,
    input  logic [vdlv_pkg::COUNT_BITS-1:0]         i_line_next,
    output logic                                    o_gt,
    output logic [vdlv_pkg::RATIO_BITS-1:0]         o_ratio
);
    import vdlv_pkg::*;

    logic signed [OPND_BITS-1:0] opnd [NUM_OPND];
    logic signed [OPND_BITS-1:0] opnd_a;
    logic signed [OPND_BITS-1:0] opnd_b;
    logic signed [PROD_BITS-1:0] n_prod;
    logic signed [PROD_BITS-1:0] r_prod;
    t_uop                        r_ctl;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  addend;
    logic signed [ACC_BITS-1:0]  n_acc;
    logic signed [ACC_BITS-1:0]  r_acc;

    logic [VN_BITS-1:0]          r_vn;
    logic [DN_BITS-1:0]          r_dn;
    logic [P_BITS-1:0]           r_p;
    logic [R_BITS-1:0]           r_r;
    logic [DOT_BITS-1:0]         r_dot;
    logic [RATIO_BITS-1:0]       r_ratio;

    // Dot product is kept signed; its square is built from an unsigned low
    // limb and a signed high limb, so no absolute value is needed.
    always_comb begin
        opnd[OP_ZERO]    = '0;
        opnd[OP_DX]      = OPND_BITS'(i_dx);
        opnd[OP_DY]      = OPND_BITS'(i_dy);
        opnd[OP_DZ]      = OPND_BITS'(i_dz);
        opnd[OP_VX]      = OPND_BITS'(i_cfg.dir_x);
        opnd[OP_VY]      = OPND_BITS'(i_cfg.dir_y);
        opnd[OP_VZ]      = OPND_BITS'(i_cfg.dir_z);
        opnd[OP_DN_LO]   = OPND_BITS'(r_dn[LIMB-1:0]);
        opnd[OP_DN_HI]   = OPND_BITS'(r_dn[DN_BITS-1:LIMB]);
        opnd[OP_VN]      = OPND_BITS'(r_vn);
        opnd[OP_P_LO]    = OPND_BITS'(r_p[LIMB-1:0]);
        opnd[OP_P_MID]   = OPND_BITS'(r_p[2*LIMB-1:LIMB]);
        opnd[OP_P_HI]    = OPND_BITS'(r_p[P_BITS-1:2*LIMB]);
        opnd[OP_COS]     = OPND_BITS'(i_cfg.cos_sq);
        opnd[OP_DOT_LO]  = OPND_BITS'(r_dot[LIMB-1:0]);
        opnd[OP_DOT_HI]  = OPND_BITS'($signed(r_dot[DOT_BITS-1:LIMB]));
        opnd[OP_DOT_HI2] = OPND_BITS'($signed({r_dot[DOT_BITS-1:LIMB], 1'b0}));
        opnd[OP_RATIO]   = OPND_BITS'(i_cfg.min_ratio);
        opnd[OP_LINE]    = OPND_BITS'(i_line_next);
    end

    assign opnd_a   = opnd[i_uop.a];
    assign opnd_b   = opnd[i_uop.b];
    assign n_prod   = PROD_BITS'(opnd_a) * PROD_BITS'(opnd_b);
    assign prod_ext = ACC_BITS'(r_prod);

    always_comb begin
        case (r_ctl.shift)
            2'd0:    addend = prod_ext;
            2'd1:    addend = prod_ext <<< LIMB;
            2'd2:    addend = prod_ext <<< (2 * LIMB);
            default: addend = '0;
        endcase
        n_acc = (r_ctl.clear ? '0 : r_acc) + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= UOP_NOP;
        end else begin
            r_ctl <= i_uop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_ctl.valid) begin
            r_acc <= n_acc;
            case (r_ctl.store)
                STORE_RATIO: r_ratio <= n_acc[RATIO_BITS-1:0];
                STORE_VN:    r_vn    <= n_acc[VN_BITS-1:0];
                STORE_DN:    r_dn    <= n_acc[DN_BITS-1:0];
                STORE_P:     r_p     <= n_acc[P_BITS-1:0];
                STORE_R:     r_r     <= n_acc[R_BITS-1:0];
                STORE_DOT:   r_dot   <= n_acc[DOT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Left side is the squared dot product scaled by 2^32.
    assign o_gt    = {r_acc[ACC_BITS-LIMB-1:0], LIMB'(0)} > ACC_BITS'(r_r);
    assign o_ratio = r_ratio;

endmodule
